[rtl/nhtl_pkg.sv]
`default_nettype none

package nhtl_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;

	localparam int CNT_W   = 13;
	localparam int IDX_W   = 12;
	localparam int ID_W    = 32;
	localparam int CHAR_W  = 8;
	localparam int IN_DW   = 56;
	localparam int OUT_DW  = 48;

	localparam logic        CMD_WRITE = 1'b0;
	localparam logic        CMD_CHAR  = 1'b1;

	localparam logic [31:0] HASH_MOD  = 32'h8000000B;
	localparam logic [31:0] FINAL_XOR = 32'h12345678;

	localparam logic [7:0]  CHAR_SLASH  = 8'h2F;
	localparam logic [7:0]  CHAR_BSLASH = 8'h5C;
	localparam logic [7:0]  CHAR_UA     = 8'h41;
	localparam logic [7:0]  CHAR_UZ     = 8'h5A;
	localparam logic [7:0]  CASE_OFS    = 8'h20;

	typedef struct packed {
		logic start;
		logic clear;
	} fold_ctrl_t;

	typedef struct packed {
		logic start;
		logic ack;
	} srch_ctrl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             found;
		logic [IDX_W-1:0] index;
		logic [ID_W-1:0]  key;
	} srch_stat_t;

	// Map '/' to backslash, fold upper case, then sign-extend as a signed char.
	function automatic logic [31:0] norm_char(input logic [7:0] c);
		logic [7:0] n;
		n = (c == CHAR_SLASH) ? CHAR_BSLASH : c;
		if (n inside {[CHAR_UA:CHAR_UZ]}) begin
			n = n + CASE_OFS;
		end
		return {{24{n[7]}}, n};
	endfunction

endpackage

`default_nettype wire

[rtl/name_hash_table_lookup.sv]
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: entry_index, entry_id, name_char; tuser: cmd;
//                                   tlast: last_char
// m_*       out  m_tvalid/m_tready  tdata: match_index, name_id; tuser: found
// cfg_*     in   cfg_we             cfg_wdata: entry_count
//
// A name character passes through the fold unit in order: normalize, 32x32 multiply,
// add and modular reduce, finish.
// The last character then adds the binary search: each probe reads the table RAM's
// registered read port and compares the entry it returns with the key.
// Reset clears control state and the hash; table contents are undefined until written.
// A result waits in the output register; the next transaction is taken meanwhile,
// and a later search holds its result until that register drains.

module name_hash_table_lookup import nhtl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_DW-1:0]  s_tdata,   // [11:0] entry_index, [43:12] entry_id,
	                                          // [51:44] name_char, [55:52] zero
	input  wire logic              s_tuser,   // [0] cmd
	input  wire logic              s_tlast,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_DW-1:0]      m_tdata,   // [11:0] match_index, [43:12] name_id,
	                                          // [47:44] zero
	output logic                   m_tuser,   // [0] found
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_wdata
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_FOLD = 2'd1;
	localparam logic [1:0] T_SRCH = 2'd2;

	logic [1:0]        state_q;
	logic              last_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic              m_tvalid_q;
	logic              out_found_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [ID_W-1:0]   out_id_q;

	logic              acc;
	logic [IDX_W-1:0]  in_idx;
	logic [ID_W-1:0]   in_id;
	logic [CHAR_W-1:0] in_char;
	logic [31:0]       idx_ext;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ID_W-1:0]   ram_rdata;
	logic [CW-1:0]     count_clip;
	logic              out_free;

	fold_ctrl_t        fold_ctrl;
	logic              fold_busy;
	logic              fold_done;
	logic [ID_W-1:0]   fold_hash;
	srch_ctrl_t        srch_ctrl;
	srch_stat_t        srch_stat;

	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_id   = s_tdata[IDX_W+ID_W-1:IDX_W];
	assign in_char = s_tdata[IDX_W+ID_W+CHAR_W-1:IDX_W+ID_W];

	assign s_tready = (state_q == T_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Drop writes beyond the table.
	assign idx_ext   = 32'(in_idx);
	assign ram_we    = acc && (s_tuser == CMD_WRITE) && (idx_ext < 32'(TABLE_DEPTH));
	assign ram_waddr = idx_ext[AW-1:0];

	assign count_clip = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
	                                                            : CW'(entry_count_q);

	assign fold_ctrl.start = acc && (s_tuser == CMD_CHAR);
	assign fold_ctrl.clear = (state_q == T_FOLD) && fold_done && last_q;
	assign srch_ctrl.start = (state_q == T_FOLD) && fold_done && last_q;
	assign srch_ctrl.ack   = (state_q == T_SRCH) && srch_stat.done && out_free;

	nhtl_ram #(
		.WIDTH (ID_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_id),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	nhtl_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fold_ctrl),
		.name_char (in_char),
		.busy      (fold_busy),
		.done      (fold_done),
		.hash      (fold_hash)
	);

	nhtl_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (srch_ctrl),
		.key     (fold_hash ^ FINAL_XOR),
		.count   (count_clip),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.stat    (srch_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			last_q        <= 1'b0;
			entry_count_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end
			if (srch_ctrl.ack) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (fold_ctrl.start) begin
						last_q  <= s_tlast;
						state_q <= T_FOLD;
					end
				end
				T_FOLD: begin
					if (fold_done) begin
						state_q <= last_q ? T_SRCH : T_IDLE;
					end
				end
				T_SRCH: begin
					// Hold the result in the search unit until the output register frees.
					if (srch_ctrl.ack) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (srch_ctrl.ack) begin
			out_found_q <= srch_stat.found;
			out_idx_q   <= srch_stat.index;
			out_id_q    <= srch_stat.key;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {{(OUT_DW-IDX_W-ID_W){1'b0}}, out_id_q, out_idx_q};

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(fold_busy && srch_stat.busy))
		else $error("fold unit and search unit active together");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[IDX_W-1:0] == '0))
		else $error("miss reported with nonzero match index");

	a_result_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == T_SRCH))
		else $error("result presented without a finished search");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(fold_busy || srch_stat.busy) |-> !(s_tvalid && s_tready))
		else $error("transaction accepted while a unit is busy");

endmodule

`default_nettype wire

[rtl/nhtl_ram.sv]
`default_nettype none

module nhtl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/nhtl_fold.sv]
`default_nettype none

module nhtl_fold import nhtl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fold_ctrl_t        ctrl,
	input  wire logic [CHAR_W-1:0] name_char,
	output logic                   busy,
	output logic                   done,
	output logic [ID_W-1:0]        hash
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_RED  = 2'd2;
	localparam logic [1:0] F_FIN  = 2'd3;

	logic [1:0]  state_q;
	logic        done_q;
	logic [31:0] hash_q;
	logic [31:0] pos1_q;
	logic [31:0] u_q;
	logic [31:0] prod_q;
	logic [31:0] red_q;
	logic [31:0] sum;
	logic [31:0] red;

	// Sum is below twice the modulus, so one conditional subtract reduces it.
	assign sum = prod_q + hash_q;
	assign red = (sum >= HASH_MOD) ? (sum - HASH_MOD) : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
			hash_q  <= '0;
			pos1_q  <= 32'd1;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (ctrl.clear) begin
						hash_q <= '0;
						pos1_q <= 32'd1;
					end
					if (ctrl.start) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_RED;
				end
				F_RED: begin
					state_q <= F_FIN;
				end
				F_FIN: begin
					// h = -16h - h, modulo 2^32
					hash_q  <= ((~red_q + 32'd1) << 4) - red_q;
					pos1_q  <= pos1_q + 32'd1;
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && ctrl.start) begin
			u_q <= norm_char(name_char);
		end
		if (state_q == F_MUL) begin
			prod_q <= 32'(u_q * pos1_q);
		end
		if (state_q == F_RED) begin
			red_q <= red;
		end
	end

	assign busy = (state_q != F_IDLE);
	assign done = done_q;
	assign hash = hash_q;

endmodule

`default_nettype wire

[rtl/nhtl_search.sv]
`default_nettype none

module nhtl_search import nhtl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire srch_ctrl_t                           ctrl,
	input  wire logic [ID_W-1:0]                      key,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
	output logic                                      rd_en,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
	input  wire logic [ID_W-1:0]                      rd_data,
	output srch_stat_t                                stat
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADDR = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]      state_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hx_q;
	logic [CW-1:0]   mid_q;
	logic [ID_W-1:0] key_q;
	logic            found_q;
	logic [IDX_W-1:0] index_q;
	logic [CW-1:0]   span;
	logic [CW-1:0]   mid;
	logic [31:0]     mid_ext;
	logic [31:0]     midq_ext;

	// Window is [lo, hx); probe the lower middle entry.
	assign span     = CW'(hx_q - lo_q - CW'(1));
	assign mid      = lo_q + (span >> 1);
	assign mid_ext  = 32'(mid);
	assign midq_ext = 32'(mid_q);

	assign rd_en   = (state_q == S_ADDR) && (lo_q < hx_q);
	assign rd_addr = mid_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
			index_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.start) begin
						found_q <= 1'b0;
						index_q <= '0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					if (lo_q < hx_q) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CMP: begin
					if (rd_data == key_q) begin
						found_q <= 1'b1;
						index_q <= midq_ext[IDX_W-1:0];
						state_q <= S_DONE;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_DONE: begin
					if (ctrl.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && ctrl.start) begin
			lo_q  <= '0;
			hx_q  <= count;
			key_q <= key;
		end
		if (state_q == S_ADDR) begin
			mid_q <= mid;
		end
		if (state_q == S_CMP && rd_data != key_q) begin
			if (key_q > rd_data) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hx_q <= mid_q;
			end
		end
	end

	assign stat.busy  = (state_q != S_IDLE);
	assign stat.done  = (state_q == S_DONE);
	assign stat.found = found_q;
	assign stat.index = index_q;
	assign stat.key   = key_q;

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench import nhtl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 20;
	localparam int TBL_DEPTH     = TABLE_DEPTH_DEF;
	localparam int BIG_N         = 200;
	localparam int POOL_N        = 32;
	localparam int MAX_LEN       = 40;
	localparam int SETTLE_CYCLES = 48;
	localparam int HOLD_CYCLES   = 600;
	localparam int LIMIT_NS      = 20_000_000;
	localparam int N_DIRECTED    = 17;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  index;
		logic [ID_W-1:0]   id;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} lookup_req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
		logic [ID_W-1:0]  name_id;
	} lookup_res_t;

	// typed: found and index below stand in for the predicted ones
	typedef struct packed {
		lookup_req_t      req;
		logic             typed;
		logic             found;
		logic [IDX_W-1:0] index;
	} dir_row_t;

	// Run at entry_count 0 straight after reset: no name can be found.
	localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h41, 1'b1}, 1'b1, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h00, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h2F, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_WRITE, 12'h000, 32'h0000_0000, 8'h00, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'hFFF, 32'hFFFF_FFFF, 8'h80, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'hFF, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h5A, 1'b1}, 1'b1, 1'b0, 12'h000},
		'{'{CMD_WRITE, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_WRITE, 12'h555, 32'hAAAA_5555, 8'h00, 1'b1}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_WRITE, 12'hAAA, 32'h5555_AAAA, 8'h00, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h5C, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h7F, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h61, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h40, 1'b0}, 1'b0, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h5B, 1'b1}, 1'b1, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'h000, 32'h0000_0000, 8'h2F, 1'b1}, 1'b1, 1'b0, 12'h000},
		'{'{CMD_CHAR,  12'hFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1}, 1'b1, 1'b0, 12'h000}
	};

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata   = '0;
	logic              s_tuser   = 1'b0;
	logic              s_tlast   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic              m_tuser;
	logic              cfg_we    = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata = '0;

	// predictor state
	logic [ID_W-1:0]   id_shadow [TBL_DEPTH];
	logic [31:0]       hash_acc   = '0;
	logic [31:0]       char_pos   = '0;
	logic [CNT_W-1:0]  table_count = '0;
	lookup_res_t       pending_lookups [$];

	logic [7:0]        pool_chars [POOL_N+1][MAX_LEN];
	int                pool_len   [POOL_N+1];
	int                pool_size  = 0;

	int errors        = 0;
	int items_in      = 0;
	int names_sent    = 0;
	int results_seen  = 0;
	int hits_seen     = 0;
	int count_writes  = 0;
	int burst_left    = 0;

	logic hold_req    = 1'b0;
	logic hold_served = 1'b0;
	int   hold_left   = 0;
	int   rx_mode     = 0;
	int   rx_mode_left = 0;

	name_hash_table_lookup i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	function automatic logic [31:0] fold_name_char(input logic [31:0] h, input logic [31:0] pos,
	                                               input logic [7:0] raw);
		logic [7:0]  c;
		logic [31:0] u;
		logic [31:0] sum;
		logic [31:0] r;
		logic [31:0] t;
		c = (raw == CHAR_SLASH) ? CHAR_BSLASH : raw;
		if (c >= CHAR_UA && c <= CHAR_UZ) begin
			c = c + CASE_OFS;
		end
		u = {{24{c[7]}}, c};
		sum = u * (pos + 32'd1);
		sum = sum + h;
		r = sum % HASH_MOD;
		t = ((r ^ 32'hFFFF_FFFF) + 32'd1) << 4;
		return t - r;
	endfunction

	function automatic lookup_res_t search_ids(input logic [31:0] key);
		lookup_res_t res;
		int cnt;
		int lo;
		int hi;
		int mid;
		res.found   = 1'b0;
		res.index   = '0;
		res.name_id = key;
		cnt = (int'(table_count) > TBL_DEPTH) ? TBL_DEPTH : int'(table_count);
		lo = 0;
		hi = cnt - 1;
		while (lo <= hi) begin
			mid = (hi - lo) / 2 + lo;
			if (id_shadow[mid] == key) begin
				res.found = 1'b1;
				res.index = mid[IDX_W-1:0];
				return res;
			end else if (key > id_shadow[mid]) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return res;
	endfunction

	function automatic logic [31:0] name_key(input int slot);
		logic [31:0] h;
		h = '0;
		for (int i = 0; i < pool_len[slot]; i++) begin
			h = fold_name_char(h, i, pool_chars[slot][i]);
		end
		return h ^ FINAL_XOR;
	endfunction

	function automatic logic [7:0] random_char();
		case ($urandom_range(0, 7))
			0: return 8'h41 + 8'($urandom_range(0, 25));
			1: return 8'h61 + 8'($urandom_range(0, 25));
			2: return CHAR_SLASH;
			3: return CHAR_BSLASH;
			4: return 8'($urandom_range(8'h80, 8'hFF));
			5: return 8'($urandom_range(0, 8'h7F));
			6: return ($urandom_range(0, 1) == 0) ? 8'h2E : 8'h30 + 8'($urandom_range(0, 9));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic make_name(input int slot);
		pool_len[slot] = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_LEN) :
		                                               $urandom_range(1, 8);
		for (int i = 0; i < pool_len[slot]; i++) begin
			pool_chars[slot][i] = random_char();
		end
	endtask

	// Called and returns at a falling edge; inputs change only there.
	task automatic put_item(input lookup_req_t r, input logic typed, input logic t_found,
	                        input logic [IDX_W-1:0] t_index);
		int gap;
		lookup_res_t want;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 300) :
			                                           $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DW-52){1'b0}}, r.ch, r.id, r.index};
		s_tuser  <= r.cmd;
		s_tlast  <= r.last;
		do @(posedge clk); while (!s_tready);
		items_in++;
		burst_left--;
		if (r.cmd == CMD_WRITE) begin
			id_shadow[r.index] = r.id;
		end else begin
			hash_acc = fold_name_char(hash_acc, char_pos, r.ch);
			char_pos = char_pos + 32'd1;
			if (r.last) begin
				want = search_ids(hash_acc ^ FINAL_XOR);
				if (typed) begin
					want.found = t_found;
					want.index = t_index;
				end
				pending_lookups.push_back(want);
				hash_acc = '0;
				char_pos = '0;
				names_sent++;
			end
		end
		@(negedge clk);
	endtask

	task automatic put_write(input int idx, input logic [31:0] id);
		lookup_req_t r;
		r.cmd   = CMD_WRITE;
		r.index = idx[IDX_W-1:0];
		r.id    = id;
		r.ch    = 8'($urandom);
		r.last  = 1'($urandom);
		put_item(r, 1'b0, 1'b0, '0);
	endtask

	// Interleave stray table writes; keep them off the searched range unless asked or the count spans the table.
	task automatic send_name(input int slot, input logic anywhere);
		lookup_req_t r;
		int idx;
		for (int i = 0; i < pool_len[slot]; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				if (anywhere || int'(table_count) >= TBL_DEPTH) begin
					idx = $urandom_range(0, TBL_DEPTH - 1);
				end else begin
					idx = $urandom_range(int'(table_count), TBL_DEPTH - 1);
				end
				put_write(idx, $urandom);
			end
			r.cmd   = CMD_CHAR;
			r.index = 12'($urandom);
			r.id    = $urandom;
			r.ch    = pool_chars[slot][i];
			r.last  = (i == pool_len[slot] - 1);
			put_item(r, 1'b0, 1'b0, '0);
		end
	endtask

	task automatic run_names(input int budget, input logic anywhere);
		int start;
		int slot;
		start = items_in;
		while (items_in - start < budget) begin
			if (pool_size > 0 && $urandom_range(0, 9) < 7) begin
				slot = $urandom_range(0, pool_size - 1);
			end else begin
				slot = POOL_N;
				make_name(slot);
			end
			send_name(slot, anywhere);
		end
	endtask

	// Fill entries 0..n-1 with the keys of a fresh name pool plus random fill.
	task automatic load_table(input int n, input logic sorted);
		logic [31:0] vals [$];
		vals = {};
		pool_size = (n < POOL_N) ? n : POOL_N;
		for (int k = 0; k < pool_size; k++) begin
			make_name(k);
			vals.push_back(name_key(k));
		end
		while (vals.size() < n) begin
			vals.push_back($urandom);
		end
		if (sorted) begin
			vals.sort();
		end else begin
			vals.shuffle();
		end
		for (int i = 0; i < n; i++) begin
			put_write(i, vals[i]);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_lookups.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_count(input int v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v[CNT_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
		table_count = v[CNT_W-1:0];
		count_writes++;
	endtask

	// Receiver: change stall pattern now and then; serve one long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_served) begin
			m_tready <= 1'b0;
			hold_served = 1'b1;
			hold_left = HOLD_CYCLES - 1;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(32, 400);
			end
			rx_mode_left--;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= rx_mode_left[2];
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		lookup_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				$error("result with nothing pending: found=%0b match_index=%0d name_id=%08h",
				       m_tuser, m_tdata[11:0], m_tdata[43:12]);
				errors++;
			end else begin
				want = pending_lookups.pop_front();
				results_seen++;
				if (want.found) begin
					hits_seen++;
				end
				if (m_tuser !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, m_tuser);
					errors++;
				end
				if (m_tdata[11:0] !== want.index) begin
					$error("match_index: expected %0d, got %0d", want.index, m_tdata[11:0]);
					errors++;
				end
				if (m_tdata[43:12] !== want.name_id) begin
					$error("name_id: expected %08h, got %08h", want.name_id, m_tdata[43:12]);
					errors++;
				end
			end
		end
	end

	initial begin
		#LIMIT_NS;
		$display("timeout with %0d lookups outstanding", pending_lookups.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			put_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].found,
			         DIRECTED_ROWS[i].index);
		end

		load_table(1, 1'b1);
		set_count(1);
		run_names(60, 1'b0);

		load_table($urandom_range(2, 40), 1'b1);
		set_count(pool_size);
		hold_req = 1'b1;
		run_names(200, 1'b0);

		// unsorted table: the halving search may miss keys that are present
		load_table(30, 1'b0);
		set_count(30);
		run_names(120, 1'b1);
		set_count($urandom_range(1, 29));
		run_names(100, 1'b0);

		load_table(BIG_N, 1'b1);
		set_count(BIG_N);
		run_names(150, 1'b0);
		set_count(0);
		run_names(80, 1'b0);
		for (int p = 0; p < 2; p++) begin
			set_count($urandom_range(1, BIG_N));
			run_names(80, 1'b0);
		end

		load_table($urandom_range(2, 64), 1'b1);
		set_count(pool_size);
		run_names(100, 1'b0);

		drain();
		$display("%0d transactions in, %0d names looked up, %0d results checked (%0d hits)",
		         items_in, names_sent, results_seen, hits_seen);
		$display("%0d entry_count settings, long receiver hold-off served: %0b",
		         count_writes, hold_served);
		if (errors == 0 && pending_lookups.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
